// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL. Clock and reset names follow the house ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TMP_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
  else $error("tmprof assertion failed");
`define TMP_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk_i) prop) \
  else $error("tmprof assertion failed");
`else
`define TMP_ASSERT(lbl, prop)
`define TMP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- src/tmprof_pkg.sv -----
package tmprof_pkg;

  localparam logic [2:0] PH_BEFORE = 3'd0;
  localparam logic [2:0] PH_ACCEL  = 3'd1;
  localparam logic [2:0] PH_CRUISE = 3'd2;
  localparam logic [2:0] PH_DECEL  = 3'd3;
  localparam logic [2:0] PH_AFTER  = 3'd4;

  localparam logic [2:0] REG_START_TIME  = 3'd0;
  localparam logic [2:0] REG_END_TIME    = 3'd1;
  localparam logic [2:0] REG_START_POS   = 3'd2;
  localparam logic [2:0] REG_END_POS     = 3'd3;
  localparam logic [2:0] REG_CRUISE_SPD  = 3'd4;

  // Quotient bits produced by the divider, one per stage.
  localparam int unsigned DIV_STAGES = 62;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic [30:0] cruise_spd;
  } tmprof_cfg_t;

  // Phase decision handed from the front end to the multiplier stages.
  typedef struct packed {
    logic [2:0]  phase;
    logic        infeasible;
    logic [62:0] n;
    logic [62:0] x;
    logic [62:0] a;
  } tmprof_sel_t;

  // Fields that travel alongside the divider.
  typedef struct packed {
    logic [2:0]  phase;
    logic        infeasible;
    logic        nzero;
    logic [31:0] cpos;
  } tmprof_side_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] x);
    logic [31:0] r;
    if (x > 66'sd2147483647) begin
      r = SAT_MAX;
    end else if (x < -66'sd2147483648) begin
      r = SAT_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ----- src/tmprof_front.sv -----
module tmprof_front import tmprof_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tmprof_cfg_t cfg_i,
  input  logic        accept_i,
  input  logic [31:0] sample_time_i,
  output logic        sel_valid_o,
  output tmprof_sel_t sel_o
);

  logic        v1_q, v2_q, v3_q, v4_q;
  logic [31:0] t_q;

  // Stage 2: time differences and v*T.
  logic [31:0]        dt_q, r_q;
  logic               lt0_q, lt1_q, le1_q;
  logic signed [64:0] vspan_q;
  logic signed [32:0] span_w;
  logic signed [31:0] vs_w;

  // Stage 3: N and the two ramp distances.
  logic signed [64:0] nsig_q;
  logic [62:0]        a_q, b_q;
  logic               lt0_s3_q, lt1_s3_q, le1_s3_q;
  logic signed [32:0] h_w;

  tmprof_sel_t sel_d, sel_q;
  logic [62:0] n_w;

  assign span_w = $signed({1'b0, cfg_i.end_time}) - $signed({1'b0, cfg_i.start_time});
  assign vs_w   = $signed({1'b0, cfg_i.cruise_spd});
  assign h_w    = $signed({cfg_i.end_pos[31], cfg_i.end_pos})
                - $signed({cfg_i.start_pos[31], cfg_i.start_pos});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q      <= sample_time_i;
    dt_q     <= t_q - cfg_i.start_time;
    r_q      <= cfg_i.end_time - t_q;
    lt0_q    <= t_q < cfg_i.start_time;
    lt1_q    <= t_q < cfg_i.end_time;
    le1_q    <= t_q <= cfg_i.end_time;
    vspan_q  <= 65'(vs_w * span_w);
    nsig_q   <= vspan_q - 65'(h_w);
    a_q      <= 63'(cfg_i.cruise_spd * dt_q);
    b_q      <= 63'(cfg_i.cruise_spd * r_q);
    lt0_s3_q <= lt0_q;
    lt1_s3_q <= lt1_q;
    le1_s3_q <= le1_q;
    sel_q    <= sel_d;
  end

  assign n_w = nsig_q[62:0];

  always_comb begin
    sel_d            = '0;
    sel_d.infeasible = nsig_q[64];
    sel_d.n          = n_w;
    sel_d.a          = a_q;
    if (lt0_s3_q) begin
      sel_d.phase = PH_BEFORE;
    end else if (a_q <= n_w) begin
      sel_d.phase = PH_ACCEL;
    end else if (lt1_s3_q && (b_q > n_w)) begin
      sel_d.phase = PH_CRUISE;
    end else if (le1_s3_q) begin
      sel_d.phase = PH_DECEL;
    end else begin
      sel_d.phase = PH_AFTER;
    end
    sel_d.x = (sel_d.phase == PH_ACCEL) ? a_q : b_q;
  end

  assign sel_valid_o = v4_q;
  assign sel_o       = sel_q;

endmodule

// ----- src/tmprof_mult.sv -----
module tmprof_mult import tmprof_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tmprof_cfg_t   cfg_i,
  input  logic          sel_valid_i,
  input  tmprof_sel_t   sel_i,
  output logic          ops_valid_o,
  output tmprof_side_t  side_o,
  output logic [125:0]  num_pos_o,
  output logic [125:0]  num_vel_o,
  output logic [125:0]  num_acc_o,
  output logic [63:0]   den_pos_o,
  output logic [63:0]   den_n_o
);

  logic v1_q, v2_q;

  // First stage: partial products of x*x, v*x and v*v.
  logic [61:0] hh_q, vh_q, vv_q;
  logic [62:0] hl_q, vl_q;
  logic [63:0] ll_q;
  logic [30:0] xh_w;
  logic [31:0] xl_w;
  logic [63:0] nh_w;
  logic signed [65:0] cpos_q;
  logic [62:0] n1_q;
  logic [2:0]  ph1_q;
  logic        inf1_q;

  tmprof_side_t side_q;
  logic [125:0] num_pos_q, num_vel_q, num_acc_q;
  logic [63:0]  den_pos_q, den_n_q;

  assign xh_w = sel_i.x[62:32];
  assign xl_w = sel_i.x[31:0];
  assign nh_w = {1'b0, sel_i.n} + 64'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= sel_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hh_q   <= 62'(xh_w * xh_w);
    hl_q   <= 63'(xh_w * xl_w);
    ll_q   <= 64'(xl_w * xl_w);
    vh_q   <= 62'(cfg_i.cruise_spd * xh_w);
    vl_q   <= 63'(cfg_i.cruise_spd * xl_w);
    vv_q   <= 62'(cfg_i.cruise_spd * cfg_i.cruise_spd);
    // Cruise position: start plus distance run minus half the ramp, rounded so it floors.
    cpos_q <= $signed({{34{cfg_i.start_pos[31]}}, cfg_i.start_pos})
            + $signed({3'b0, sel_i.a}) - $signed({3'b0, nh_w[63:1]});
    n1_q   <= sel_i.n;
    ph1_q  <= sel_i.phase;
    inf1_q <= sel_i.infeasible;

    num_pos_q <= {hh_q, 64'b0} + {30'b0, hl_q, 33'b0} + {62'b0, ll_q};
    num_vel_q <= {32'b0, ({vh_q, 32'b0} + {31'b0, vl_q})};
    num_acc_q <= {64'b0, vv_q};
    den_pos_q <= {n1_q, 1'b0};
    den_n_q   <= {1'b0, n1_q};
    side_q.phase      <= ph1_q;
    side_q.infeasible <= inf1_q;
    side_q.nzero      <= (n1_q == '0);
    side_q.cpos       <= sat32(cpos_q);
  end

  assign ops_valid_o = v2_q;
  assign side_o      = side_q;
  assign num_pos_o   = num_pos_q;
  assign num_vel_o   = num_vel_q;
  assign num_acc_o   = num_acc_q;
  assign den_pos_o   = den_pos_q;
  assign den_n_o     = den_n_q;

endmodule

// ----- src/tmprof_div.sv -----
module tmprof_div import tmprof_pkg::*; (
  input  logic          clk_i,
  input  logic [125:0]  num_i,
  input  logic [63:0]   den_i,
  output logic [DIV_STAGES-1:0] quo_o
);

  // Restoring division, one quotient bit per stage. The upper part of the
  // dividend must lie below the divisor; the low word shifts out while
  // quotient bits shift in behind it.
  logic [63:0]           rem_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] w_q   [DIV_STAGES];
  logic [63:0]           den_q [DIV_STAGES-1];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [63:0]           rem_in;
    logic [63:0]           den_in;
    logic [DIV_STAGES-1:0] w_in;
    logic [64:0]           trial;
    logic [64:0]           diff;
    logic                  take;

    if (k == 0) begin : g_first
      assign rem_in = num_i[125:62];
      assign w_in   = num_i[61:0];
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign w_in   = w_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, w_in[DIV_STAGES-1]};
    assign take  = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? diff[63:0] : trial[63:0];
      w_q[k]   <= {w_in[DIV_STAGES-2:0], take};
    end

    if (k < DIV_STAGES - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = w_q[DIV_STAGES-1];

endmodule

// ----- src/trapezoidal_motion_profile_core.sv -----
// Trapezoidal move evaluator: one sample time in, one set-point out, position,
// velocity and acceleration with a phase code. A new sample is taken in every
// cycle and busy never rises; the result for a sample is on the outputs, marked
// by done_o, for one cycle only, since the receiver cannot hold results off. It
// passes the phase decision, the split wide products, the 62-stage pipelined
// divider that forms the ramp quotients and the output register, in that
// order. Registers may only be written while no sample is in flight.
`include "assert_macros.svh"

module trapezoidal_motion_profile_core import tmprof_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] sample_time_i,
  output logic [31:0] position_o,
  output logic [31:0] velocity_o,
  output logic [31:0] acceleration_o,
  output logic [2:0]  phase_o,
  output logic        infeasible_o,
  output logic        done_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tmprof_cfg_t cfg_q;
  logic [2:0]  widx_w;
  logic        wr_w;

  logic         sel_valid_w, ops_valid_w;
  tmprof_sel_t  sel_w;
  tmprof_side_t side_w;
  logic [125:0] num_pos_w, num_vel_w, num_acc_w;
  logic [63:0]  den_pos_w, den_n_w;
  logic [DIV_STAGES-1:0] qp_w, qv_w, qa_w;

  tmprof_side_t          dly_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] dvld_q;
  tmprof_side_t          s_w;

  logic [31:0] pos_d, vel_d, acc_d, pos_q, vel_q, acc_q;
  logic [2:0]  ph_d, ph_q;
  logic        inf_d, inf_q, done_q;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign widx_w = paddr[4:2];
  assign wr_w   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_w) begin
      unique case (widx_w)
        REG_START_TIME: cfg_q.start_time <= pwdata;
        REG_END_TIME:   cfg_q.end_time   <= pwdata;
        REG_START_POS:  cfg_q.start_pos  <= pwdata;
        REG_END_POS:    cfg_q.end_pos    <= pwdata;
        REG_CRUISE_SPD: cfg_q.cruise_spd <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx_w)
      REG_START_TIME: prdata = cfg_q.start_time;
      REG_END_TIME:   prdata = cfg_q.end_time;
      REG_START_POS:  prdata = cfg_q.start_pos;
      REG_END_POS:    prdata = cfg_q.end_pos;
      REG_CRUISE_SPD: prdata = {1'b0, cfg_q.cruise_spd};
      default:        prdata = '0;
    endcase
  end

  tmprof_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (start && !busy),
    .sample_time_i (sample_time_i),
    .sel_valid_o   (sel_valid_w),
    .sel_o         (sel_w)
  );

  tmprof_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .sel_valid_i (sel_valid_w),
    .sel_i       (sel_w),
    .ops_valid_o (ops_valid_w),
    .side_o      (side_w),
    .num_pos_o   (num_pos_w),
    .num_vel_o   (num_vel_w),
    .num_acc_o   (num_acc_w),
    .den_pos_o   (den_pos_w),
    .den_n_o     (den_n_w)
  );

  tmprof_div u_div_pos (.clk_i(clk_i), .num_i(num_pos_w), .den_i(den_pos_w), .quo_o(qp_w));
  tmprof_div u_div_vel (.clk_i(clk_i), .num_i(num_vel_w), .den_i(den_n_w),   .quo_o(qv_w));
  tmprof_div u_div_acc (.clk_i(clk_i), .num_i(num_acc_w), .den_i(den_n_w),   .quo_o(qa_w));

  // Phase and flags ride along the divider so that they meet its quotients.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q <= '0;
    end else begin
      dvld_q <= {dvld_q[DIV_STAGES-2:0], ops_valid_w};
    end
  end

  always_ff @(posedge clk_i) begin
    dly_q[0] <= side_w;
    for (int i = 1; i < DIV_STAGES; i++) begin
      dly_q[i] <= dly_q[i-1];
    end
  end

  assign s_w = dly_q[DIV_STAGES-1];

  always_comb begin
    pos_d = '0;
    vel_d = '0;
    acc_d = '0;
    ph_d  = s_w.phase;
    inf_d = s_w.infeasible;
    unique case (s_w.phase)
      PH_ACCEL: begin
        pos_d = sat32($signed({{34{cfg_q.start_pos[31]}}, cfg_q.start_pos})
                      + $signed({4'b0, (s_w.nzero ? '0 : qp_w)}));
        vel_d = (s_w.nzero || (|qv_w[61:31])) ? '0 : qv_w[31:0];
        if (s_w.nzero) begin
          acc_d = (cfg_q.cruise_spd != '0) ? SAT_MAX : '0;
        end else begin
          acc_d = (|qa_w[61:31]) ? SAT_MAX : qa_w[31:0];
        end
      end
      PH_CRUISE: begin
        pos_d = s_w.cpos;
        vel_d = {1'b0, cfg_q.cruise_spd};
      end
      PH_DECEL: begin
        pos_d = sat32($signed({{34{cfg_q.end_pos[31]}}, cfg_q.end_pos})
                      - $signed({4'b0, (s_w.nzero ? '0 : qp_w)}));
        vel_d = (s_w.nzero || (|qv_w[61:31])) ? '0 : qv_w[31:0];
        if (s_w.nzero) begin
          acc_d = (cfg_q.cruise_spd != '0) ? SAT_MIN : '0;
        end else begin
          acc_d = (|qa_w[61:31]) ? SAT_MIN : (32'd0 - qa_w[31:0]);
        end
      end
      PH_AFTER: begin
        pos_d = cfg_q.end_pos;
      end
      default: ;
    endcase
    // An infeasible move reports nothing but the flag.
    if (s_w.infeasible) begin
      pos_d = '0;
      vel_d = '0;
      acc_d = '0;
      ph_d  = PH_BEFORE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dvld_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    vel_q <= vel_d;
    acc_q <= acc_d;
    ph_q  <= ph_d;
    inf_q <= inf_d;
  end

  assign position_o     = pos_q;
  assign velocity_o     = vel_q;
  assign acceleration_o = acc_q;
  assign phase_o        = ph_q;
  assign infeasible_o   = inf_q;
  assign done_o         = done_q;

  `TMP_ASSERT_ALWAYS(a_phase_range, done_o |-> phase_o <= PH_AFTER)
  `TMP_ASSERT(a_infeasible_quiet, done_o && infeasible_o |-> position_o == '0 && velocity_o == '0 && phase_o == PH_BEFORE)
  `TMP_ASSERT(a_still_ends, done_o && (phase_o == PH_BEFORE || phase_o == PH_AFTER) |-> velocity_o == '0 && acceleration_o == '0)
  `TMP_ASSERT(a_accel_sign, done_o && phase_o == PH_ACCEL |-> !acceleration_o[31] && !velocity_o[31])
  `TMP_ASSERT(a_decel_sign, done_o && phase_o == PH_DECEL |-> (acceleration_o[31] || acceleration_o == '0) && !velocity_o[31])

endmodule

// ----- bench/trapezoidal_motion_profile_core_tb.sv -----
`timescale 1ns / 1ps

module trapezoidal_motion_profile_core_tb;
  import tmprof_pkg::*;

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] acceleration;
    logic [2:0]  phase;
    logic        infeasible;
  } setpoint_t;

  // Keeps a copy of the move registers and the set-points still owed by the block.
  class setpoint_scoreboard;
    logic [31:0] t_begin;
    logic [31:0] t_end;
    longint      q_begin;
    longint      q_end;
    longint      speed;
    setpoint_t   pending[$];
    int          errors;

    function new();
      t_begin = 0;
      t_end   = 0;
      q_begin = 0;
      q_end   = 0;
      speed   = 0;
      errors  = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_START_TIME: t_begin = val;
        REG_END_TIME:   t_end   = val;
        REG_START_POS:  q_begin = longint'(signed'(val));
        REG_END_POS:    q_end   = longint'(signed'(val));
        REG_CRUISE_SPD: speed   = longint'({33'd0, val[30:0]});
        default: ;
      endcase
    endfunction

    // floor(x*y/d) over a 128 bit product, all ones when it overflows 64 bits, zero when d is zero.
    function logic [63:0] scaled_ratio(logic [63:0] x, logic [63:0] y, logic [63:0] d);
      logic [127:0] prod;
      logic [127:0] quo;
      if (d == 0) return 64'd0;
      prod = {64'd0, x} * {64'd0, y};
      quo  = prod / {64'd0, d};
      if (quo[127:64] != 0) return '1;
      return quo[63:0];
    endfunction

    function logic [31:0] clamp32(longint x);
      if (x > 64'sd2147483647) return SAT_MAX;
      if (x < -64'sd2147483648) return SAT_MIN;
      return x[31:0];
    endfunction

    function void note_sample(logic [31:0] t);
      longint      span;
      longint      travel;
      longint      nsig;
      longint      pos;
      longint      vel;
      longint      acc;
      logic [63:0] n;
      logic [63:0] ramp;
      logic [63:0] tail;
      logic [63:0] v;
      logic [31:0] dt;
      logic [31:0] rt;
      setpoint_t   e;
      span   = longint'({32'd0, t_end}) - longint'({32'd0, t_begin});
      travel = q_end - q_begin;
      nsig   = speed * span - travel;
      v      = speed;
      pos    = 0;
      vel    = 0;
      acc    = 0;
      e.phase      = PH_BEFORE;
      e.infeasible = 1'b0;
      dt = t - t_begin;
      rt = t_end - t;
      if (nsig < 0) begin
        e.infeasible = 1'b1;
      end else begin
        n    = nsig;
        ramp = v * {32'd0, dt};
        tail = v * {32'd0, rt};
        if (t < t_begin) begin
          e.phase = PH_BEFORE;
        end else if (ramp <= n) begin
          e.phase = PH_ACCEL;
          pos = q_begin + longint'(scaled_ratio(ramp, ramp, 2 * n));
          vel = longint'(scaled_ratio(v, ramp, n));
          if (n == 0) acc = (v != 0) ? 64'sd2147483647 : 0;
          else acc = longint'((v * v) / n);
        end else if (t < t_end && tail > n) begin
          e.phase = PH_CRUISE;
          pos = q_begin + longint'(ramp) - longint'((n + 1) >> 1);
          vel = longint'(v);
        end else if (t <= t_end) begin
          e.phase = PH_DECEL;
          pos = q_end - longint'(scaled_ratio(tail, tail, 2 * n));
          vel = longint'(scaled_ratio(v, tail, n));
          if (n == 0) acc = (v != 0) ? -64'sd2147483648 : 0;
          else acc = -longint'((v * v) / n);
        end else begin
          e.phase = PH_AFTER;
          pos = q_end;
        end
      end
      e.position     = clamp32(pos);
      e.velocity     = clamp32(vel);
      e.acceleration = clamp32(acc);
      pending.push_back(e);
    endfunction

    function void check_setpoint(setpoint_t got);
      setpoint_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected set-point %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.position !== e.position) begin
        $display("%0t: position exp %h act %h", $time, e.position, got.position);
        errors++;
      end
      if (got.velocity !== e.velocity) begin
        $display("%0t: velocity exp %h act %h", $time, e.velocity, got.velocity);
        errors++;
      end
      if (got.acceleration !== e.acceleration) begin
        $display("%0t: acceleration exp %h act %h", $time, e.acceleration,
                 got.acceleration);
        errors++;
      end
      if (got.phase !== e.phase) begin
        $display("%0t: phase exp %0d act %0d", $time, e.phase, got.phase);
        errors++;
      end
      if (got.infeasible !== e.infeasible) begin
        $display("%0t: infeasible exp %b act %b", $time, e.infeasible, got.infeasible);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] sample_time_i;
  logic [31:0] position_o;
  logic [31:0] velocity_o;
  logic [31:0] acceleration_o;
  logic [2:0]  phase_o;
  logic        infeasible_o;
  logic        done_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  setpoint_scoreboard sb;

  trapezoidal_motion_profile_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .sample_time_i  (sample_time_i),
    .position_o     (position_o),
    .velocity_o     (velocity_o),
    .acceleration_o (acceleration_o),
    .phase_o        (phase_o),
    .infeasible_o   (infeasible_o),
    .done_o         (done_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  // Both sides are observed at the edge, before anything driven there takes effect.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_sample(sample_time_i);
      if (done_o) sb.check_setpoint({position_o, velocity_o, acceleration_o, phase_o,
                                     infeasible_o});
    end
  end

  // The bus is left selected after the access edge; load_move releases it.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
  endtask

  // The divider pipeline is long, so let it drain fully before touching the registers.
  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic load_move(logic [31:0] t0, logic [31:0] t1, logic [31:0] q0,
                           logic [31:0] q1, logic [30:0] v);
    wait_drained();
    write_reg(REG_START_TIME, t0);
    write_reg(REG_END_TIME, t1);
    write_reg(REG_START_POS, q0);
    write_reg(REG_END_POS, q1);
    write_reg(REG_CRUISE_SPD, {1'b0, v});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_sample(logic [31:0] t, bit gaps);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (gaps) begin
      if (r >= 90) gap = $urandom_range(10, 40);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    sample_time_i <= t;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic stop_sending();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sample times around the current move, with the occasional fully random tick.
  task automatic random_samples(int count);
    logic [31:0] t;
    bit          gaps;
    gaps = $urandom_range(0, 3) != 0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) t = $urandom();
      else if (sb.t_end >= sb.t_begin)
        t = sb.t_begin - 5 + $urandom_range(0, sb.t_end - sb.t_begin + 10);
      else t = sb.t_end - 5 + $urandom_range(0, sb.t_begin - sb.t_end + 10);
      send_sample(t, gaps);
    end
    stop_sending();
  endtask

  initial begin
    logic [31:0] t0;
    logic [31:0] span;
    logic [31:0] q0;
    logic [30:0] v;
    logic [63:0] vt;
    logic [63:0] ramp;
    sb = new();
    rst_ni        = 1'b0;
    start         = 1'b0;
    sample_time_i = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: zero move, so ramp time is zero with zero speed.
    send_sample(32'd0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    stop_sending();

    // Ordinary move: h = 600, v = 1, T = 1000, so ramps of 400 ticks.
    load_move(32'd1000, 32'd2000, 32'd0, 32'd600 << 16, 31'd1 << 16);
    send_sample(32'd999, 1'b0);
    send_sample(32'd1000, 1'b0);
    send_sample(32'd1400, 1'b0);
    send_sample(32'd1401, 1'b0);
    send_sample(32'd1599, 1'b0);
    send_sample(32'd1600, 1'b0);
    send_sample(32'd2000, 1'b0);
    send_sample(32'd2001, 1'b0);
    send_sample(32'd0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    stop_sending();

    // Infeasible move: the distance cannot be covered at the cruise speed.
    load_move(32'd0, 32'd10, 32'h8000_0000, 32'h7FFF_FFFF, 31'd1);
    send_sample(32'd5, 1'b0);
    stop_sending();

    // Zero ramp time: h equals v*T exactly.
    load_move(32'd10, 32'd20, 32'd0, 32'd10 << 16, 31'd1 << 16);
    send_sample(32'd10, 1'b0);
    send_sample(32'd15, 1'b0);
    send_sample(32'd20, 1'b0);
    stop_sending();

    // Zero speed with a backward move, so the ramp never ends.
    load_move(32'd100, 32'd200, 32'd5000, 32'd0, 31'd0);
    send_sample(32'd150, 1'b0);
    send_sample(32'd300, 1'b0);
    stop_sending();

    // Reversed times, then the widest extremes with saturated outputs.
    load_move(32'd500, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
    send_sample(32'd300, 1'b0);
    send_sample(32'd600, 1'b0);
    stop_sending();
    load_move(32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
    send_sample(32'd0, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    stop_sending();

    for (int p = 0; p < 14; p++) begin
      t0   = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 5000);
      span = $urandom_range(0, 1000);
      q0   = $urandom();
      v    = ($urandom_range(0, 4) == 0) ? 31'($urandom())
                                         : 31'($urandom_range(0, 1 << 20));
      vt   = {33'd0, v} * {32'd0, span};
      case ($urandom_range(0, 5))
        0: ramp = 0;
        1: ramp = vt;
        2: ramp = -64'sd1 - 64'($urandom_range(0, 1000));
        default: ramp = (vt * $urandom_range(0, 100)) / 100;
      endcase
      load_move(t0, t0 + span, q0, q0 + 32'(vt - ramp), v);
      random_samples(85);
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
